// ----- hw/rtl/mcs_pkg.sv -----
// Shared types, codes and constants of the machine cycle supervisor.
package mcs_pkg;

    localparam int CNT_W = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] FEEDER_TIMEOUT_RST = 16'd5000;
    localparam logic [CNT_W-1:0] TEST_TIMEOUT_RST = 16'd10000;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_FEEDER_TIMEOUT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEST_TIMEOUT = 1'b1;

    // Mode codes as seen on the result channel.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_PAUSED = 2'd2;
    localparam logic [1:0] MODE_FAULT = 2'd3;

    // Fault codes.
    localparam logic [1:0] FC_NONE = 2'd0;
    localparam logic [1:0] FC_FEEDER = 2'd1;
    localparam logic [1:0] FC_TEST = 2'd2;
    localparam logic [1:0] FC_JAM = 2'd3;

    // Internal mode state, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUNNING = 4'b0010,
        ST_PAUSED = 4'b0100,
        ST_FAULT = 4'b1000
    } state_t;

    // One input item, last field in the lowest bit.
    typedef struct packed {
        logic pad;
        logic stacker_jam;
        logic feeder_jam;
        logic hopper_jam;
        logic tester_ready;
        logic feeder_isolated;
        logic pause_pressed;
        logic start_pressed;
    } sample_t;

    // One result item, last field in the lowest bits.
    typedef struct packed {
        logic       test_start;
        logic       feed_drive;
        logic       hopper_enable;
        logic       system_enable;
        logic [1:0] fault_code;
        logic [1:0] mode;
    } result_t;

    function automatic logic [1:0] mode_code(input state_t st);
        logic [1:0] code;
        case (st)
            ST_IDLE: code = MODE_IDLE;
            ST_RUNNING: code = MODE_RUNNING;
            ST_PAUSED: code = MODE_PAUSED;
            ST_FAULT: code = MODE_FAULT;
            default: code = MODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/mcs_core.sv -----
// Supervisor state registers and the per-tick update rule.
module mcs_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              tick,
    input  mcs_pkg::sample_t                  sample,
    input  logic                              cfg_we,
    input  logic [mcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mcs_pkg::CNT_W-1:0]         cfg_wdata,
    output mcs_pkg::result_t                  result
);

    logic [mcs_pkg::CNT_W-1:0] feeder_timeout_reg;
    logic [mcs_pkg::CNT_W-1:0] test_timeout_reg;

    mcs_pkg::state_t           state_reg, state_next;
    logic [1:0]                fault_reg, fault_next;
    logic                      pause_reg, pause_next;
    logic                      sys_reg, sys_next;
    logic                      hop_reg, hop_next;
    logic                      feed_reg, feed_next;
    logic                      test_reg, test_next;
    logic [mcs_pkg::CNT_W-1:0] feed_cnt_reg, feed_cnt_next;
    logic [mcs_pkg::CNT_W-1:0] test_cnt_reg, test_cnt_next;

    logic feed_fire;
    logic test_fire;
    logic jam;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feeder_timeout_reg <= mcs_pkg::FEEDER_TIMEOUT_RST;
            test_timeout_reg <= mcs_pkg::TEST_TIMEOUT_RST;
        end else if (cfg_we) begin
            if (cfg_addr == mcs_pkg::CFG_FEEDER_TIMEOUT) begin
                feeder_timeout_reg <= cfg_wdata;
            end
            if (cfg_addr == mcs_pkg::CFG_TEST_TIMEOUT) begin
                test_timeout_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        jam = sample.hopper_jam | sample.feeder_jam | sample.stacker_jam;

        state_next = state_reg;
        fault_next = fault_reg;
        pause_next = pause_reg;
        sys_next = sys_reg;
        hop_next = hop_reg;
        feed_next = feed_reg;
        test_next = test_reg;
        feed_cnt_next = feed_cnt_reg;
        test_cnt_next = test_cnt_reg;

        // Counters advance and saturate unless paused.
        if (!pause_reg) begin
            if (feed_cnt_reg != mcs_pkg::CNT_MAX) begin
                feed_cnt_next = feed_cnt_reg + 1'b1;
            end
            if (test_cnt_reg != mcs_pkg::CNT_MAX) begin
                test_cnt_next = test_cnt_reg + 1'b1;
            end
        end

        // A feeder timeout drops the drives first, so the test check then
        // sees its drive low.
        feed_fire = !pause_reg && feed_reg && (feed_cnt_next > feeder_timeout_reg);
        test_fire = !pause_reg && !feed_fire && test_reg
                    && (test_cnt_next > test_timeout_reg);

        if (feed_fire || test_fire) begin
            state_next = mcs_pkg::ST_FAULT;
            fault_next = feed_fire ? mcs_pkg::FC_FEEDER : mcs_pkg::FC_TEST;
            sys_next = 1'b0;
            hop_next = 1'b0;
            feed_next = 1'b0;
            test_next = 1'b0;
        end

        case (state_next)
            mcs_pkg::ST_IDLE: begin
                if (sample.start_pressed) begin
                    sys_next = 1'b1;
                    hop_next = 1'b1;
                    state_next = mcs_pkg::ST_RUNNING;
                end
            end
            mcs_pkg::ST_RUNNING: begin
                if (sample.start_pressed) begin
                    feed_next = 1'b0;
                end
                if (sample.feeder_isolated && sample.tester_ready) begin
                    feed_next = 1'b1;
                    test_next = 1'b1;
                    feed_cnt_next = '0;
                    test_cnt_next = '0;
                end
                if (sample.pause_pressed) begin
                    state_next = mcs_pkg::ST_PAUSED;
                    pause_next = 1'b1;
                end
                if (jam) begin
                    state_next = mcs_pkg::ST_FAULT;
                    fault_next = mcs_pkg::FC_JAM;
                    sys_next = 1'b0;
                    hop_next = 1'b0;
                    feed_next = 1'b0;
                    test_next = 1'b0;
                end
            end
            mcs_pkg::ST_PAUSED: begin
                if (sample.pause_pressed) begin
                    state_next = mcs_pkg::ST_RUNNING;
                    pause_next = 1'b0;
                end
            end
            default: begin
                if (sample.start_pressed) begin
                    fault_next = mcs_pkg::FC_NONE;
                    state_next = mcs_pkg::ST_IDLE;
                end
            end
        endcase

        result.mode = mcs_pkg::mode_code(state_next);
        result.fault_code = fault_next;
        result.system_enable = sys_next;
        result.hopper_enable = hop_next;
        result.feed_drive = feed_next;
        result.test_start = test_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcs_pkg::ST_IDLE;
            fault_reg <= mcs_pkg::FC_NONE;
            pause_reg <= 1'b0;
            sys_reg <= 1'b0;
            hop_reg <= 1'b0;
            feed_reg <= 1'b0;
            test_reg <= 1'b0;
            feed_cnt_reg <= '0;
            test_cnt_reg <= '0;
        end else if (tick) begin
            state_reg <= state_next;
            fault_reg <= fault_next;
            pause_reg <= pause_next;
            sys_reg <= sys_next;
            hop_reg <= hop_next;
            feed_reg <= feed_next;
            test_reg <= test_next;
            feed_cnt_reg <= feed_cnt_next;
            test_cnt_reg <= test_cnt_next;
        end
    end

endmodule

// ----- hw/rtl/mcs_out_buf.sv -----
// Two-entry result buffer: an output register backed by a skid register.
module mcs_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mcs_pkg::result_t push_data,
    output logic             can_push,
    output logic             out_valid,
    input  logic             out_ready,
    output mcs_pkg::result_t out_data
);

    mcs_pkg::result_t main_reg, main_next;
    mcs_pkg::result_t skid_reg, skid_next;
    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             pop;

    assign can_push = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_reg;
    assign pop = main_valid_reg && out_ready;

    always_comb begin
        main_next = main_reg;
        skid_next = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            // No push is possible while the skid register is full.
            if (pop) begin
                main_next = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

endmodule

// ----- hw/rtl/machine_cycle_supervisor.sv -----
// Top level of the machine cycle supervisor: input channel, core and result buffer.
//
// Each input item is one millisecond tick carrying the sampled buttons and
// sensors, all active high. For every accepted item the block returns exactly
// one result item: the mode, the fault code and the four drive levels as they
// stand after that tick.
// The state update and the result are formed by short logic in the cycle the
// item is accepted, then registered in the result buffer before it reaches the
// m_ side. One item is accepted in every cycle while results are taken.
// Results pass through a two-entry buffer, so an item is still accepted while
// one finished result waits; s_tready falls only when two results are held
// and the receiver has not taken the first.
// The two timeout registers are written through cfg_we, cfg_addr and cfg_wdata,
// one write per clock, with no items in flight: a user rule the block does not check.
// During reset (aresetn low, synchronous) the mode returns to idle, the fault
// code, pause flag, drives and both elapsed-tick counters clear, the timeouts
// return to 5000 and 10000 ticks and any buffered results are dropped.
module machine_cycle_supervisor (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata, from bit 0: start_pressed, pause_pressed, feeder_isolated,
    // tester_ready, hopper_jam, feeder_jam, stacker_jam, zero pad
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    // m_tdata, from bit 0: mode[1:0], fault_code[3:2], system_enable,
    // hopper_enable, feed_drive, test_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    input  logic                           cfg_we,
    input  logic [mcs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mcs_pkg::CNT_W-1:0]      cfg_wdata
);

    mcs_pkg::sample_t sample;
    mcs_pkg::result_t result;
    mcs_pkg::result_t out_data;
    logic             tick;
    logic             can_push;

    assign sample = mcs_pkg::sample_t'(s_tdata);
    assign s_tready = can_push;
    assign tick = s_tvalid && can_push;
    assign m_tdata = 8'(out_data);

    mcs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (tick),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    mcs_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tick),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the machine cycle supervisor: stream driver, monitor and predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcs_pkg::*;

    // Quiet cycles (no item moving on either side) that end the run as hung.
    localparam int QUIET_LIMIT = 2000;
    // Items of random stimulus in each of the six random phases.
    localparam int PHASE_TICKS = 304;

    // Bit positions of the drive levels in the predicted drive word.
    localparam int DRV_SYS = 0;
    localparam int DRV_HOPPER = 1;
    localparam int DRV_FEED = 2;
    localparam int DRV_TEST = 3;

    // Masks of the input item, used to spell out the directed ticks.
    localparam logic [7:0] TK_NONE = 8'h00;
    localparam logic [7:0] TK_START = 8'h01;
    localparam logic [7:0] TK_PAUSE = 8'h02;
    localparam logic [7:0] TK_ISOLATED = 8'h04;
    localparam logic [7:0] TK_READY = 8'h08;
    localparam logic [7:0] TK_HOPPER_JAM = 8'h10;
    localparam logic [7:0] TK_FEEDER_JAM = 8'h20;
    localparam logic [7:0] TK_STACKER_JAM = 8'h40;
    localparam logic [7:0] TK_ALL = 8'h7F;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata, from bit 0: start_pressed, pause_pressed, feeder_isolated,
    // tester_ready, hopper_jam, feeder_jam, stacker_jam, zero pad
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata, from bit 0: mode[1:0], fault_code[3:2], system_enable,
    // hopper_enable, feed_drive, test_start
    logic [7:0]            m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CNT_W-1:0]      cfg_wdata = '0;

    // Ticks waiting to be driven, and the status each accepted tick should produce.
    sample_t tick_queue[$];
    result_t expected_status[$];

    int ticks_queued = 0;
    int ticks_taken = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int settings_used = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int faults_entered [4];
    logic took_tick = 1'b0;
    logic [7:0] directed_ticks [0:26];

    // The predictor's own copy of the supervisor state and its timeout registers.
    logic [1:0]       sup_mode = MODE_IDLE;
    logic [1:0]       sup_fault = FC_NONE;
    logic             sup_frozen = 1'b0;
    logic [3:0]       sup_drive = '0;
    logic [CNT_W-1:0] feed_age = '0;
    logic [CNT_W-1:0] test_age = '0;
    logic [CNT_W-1:0] feed_limit = FEEDER_TIMEOUT_RST;
    logic [CNT_W-1:0] test_limit = TEST_TIMEOUT_RST;

    machine_cycle_supervisor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin : clock_gen
        forever #5 aclk = ~aclk;
    end

    // Any fault drops every drive; the code is remembered until start clears it.
    function automatic void enter_fault(input logic [1:0] code);
        sup_fault = code;
        sup_mode = MODE_FAULT;
        sup_drive = '0;
        faults_entered[code]++;
    endfunction

    // Works out the status after one tick. The elapsed counters move and the
    // timeouts are looked at first, and only while the machine is not frozen
    // by the pause flag. The feeder check comes first and clears the drives,
    // so a test timeout can only fire when the feeder check did not. The rule
    // of whatever mode then holds runs in the same tick.
    function automatic result_t advance_supervisor(input sample_t tick);
        result_t status;
        logic    jammed;
        jammed = tick.hopper_jam | tick.feeder_jam | tick.stacker_jam;
        if (!sup_frozen) begin
            if (feed_age != '1)
                feed_age = feed_age + 1'b1;
            if (test_age != '1)
                test_age = test_age + 1'b1;
            if (sup_drive[DRV_FEED] && feed_age > feed_limit)
                enter_fault(FC_FEEDER);
            if (sup_drive[DRV_TEST] && test_age > test_limit)
                enter_fault(FC_TEST);
        end
        case (sup_mode)
            MODE_IDLE: begin
                if (tick.start_pressed) begin
                    sup_drive[DRV_SYS] = 1'b1;
                    sup_drive[DRV_HOPPER] = 1'b1;
                    sup_mode = MODE_RUNNING;
                end
            end
            MODE_RUNNING: begin
                if (tick.start_pressed)
                    sup_drive[DRV_FEED] = 1'b0;
                if (tick.feeder_isolated && tick.tester_ready) begin
                    sup_drive[DRV_FEED] = 1'b1;
                    sup_drive[DRV_TEST] = 1'b1;
                    feed_age = '0;
                    test_age = '0;
                end
                if (tick.pause_pressed) begin
                    sup_mode = MODE_PAUSED;
                    sup_frozen = 1'b1;
                end
                // A jam wins over a pause in the same tick, but the pause
                // flag stays set, so the counters remain frozen in fault.
                if (jammed)
                    enter_fault(FC_JAM);
            end
            MODE_PAUSED: begin
                if (tick.pause_pressed) begin
                    sup_mode = MODE_RUNNING;
                    sup_frozen = 1'b0;
                end
            end
            default: begin
                if (tick.start_pressed) begin
                    sup_fault = FC_NONE;
                    sup_mode = MODE_IDLE;
                end
            end
        endcase
        status.mode = sup_mode;
        status.fault_code = sup_fault;
        status.system_enable = sup_drive[DRV_SYS];
        status.hopper_enable = sup_drive[DRV_HOPPER];
        status.feed_drive = sup_drive[DRV_FEED];
        status.test_start = sup_drive[DRV_TEST];
        return status;
    endfunction

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: result %0d: %s expected %0h, got %0h",
                 $realtime, results_checked, what, want, got);
        mismatch_count++;
    endtask

    function automatic void queue_tick(input sample_t tick);
        tick_queue.push_back(tick);
        ticks_queued++;
    endfunction

    // A random tick. Most are plausible operator and sensor activity: start
    // and pause are short presses, the feeder and tester readiness come up
    // often enough to issue feed commands, and jams are rare. One in twelve
    // is plain noise on all seven inputs.
    function automatic sample_t draw_tick();
        sample_t tick;
        tick = '0;
        if ($urandom_range(11) == 0) begin
            tick = sample_t'({1'b0, 7'($urandom)});
        end else begin
            tick.start_pressed = ($urandom_range(99) < 7);
            tick.pause_pressed = ($urandom_range(99) < 5);
            tick.feeder_isolated = ($urandom_range(99) < 35);
            tick.tester_ready = ($urandom_range(99) < 35);
            tick.hopper_jam = ($urandom_range(199) < 3);
            tick.feeder_jam = ($urandom_range(199) < 3);
            tick.stacker_jam = ($urandom_range(199) < 3);
        end
        return tick;
    endfunction

    // Random ticks with some structure: now and then a stretch of silent
    // ticks, so that running commands age past their timeouts, and now and
    // then a held pause button, which toggles the mode on every tick.
    task automatic queue_random_ticks(input int count);
        int      left;
        int      run;
        int      roll;
        sample_t tick;
        left = count;
        while (left > 0) begin
            roll = $urandom_range(99);
            tick = '0;
            if (roll < 5) begin
                run = $urandom_range(4, 20);
            end else if (roll < 9) begin
                run = $urandom_range(2, 5);
                tick.pause_pressed = 1'b1;
            end else begin
                run = 1;
                tick = draw_tick();
            end
            if (run > left)
                run = left;
            repeat (run) queue_tick(tick);
            left -= run;
        end
    endtask

    // Both timeout registers are written on consecutive clocks while the
    // block is idle; the predictor takes the new limits at the same time.
    task automatic write_timeouts(input logic [CNT_W-1:0] feeder_ticks,
                                  input logic [CNT_W-1:0] test_ticks);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_FEEDER_TIMEOUT;
        cfg_wdata <= feeder_ticks;
        @(negedge aclk);
        cfg_addr <= CFG_TEST_TIMEOUT;
        cfg_wdata <= test_ticks;
        @(negedge aclk);
        cfg_we <= 1'b0;
        feed_limit = feeder_ticks;
        test_limit = test_ticks;
        settings_used++;
    endtask

    // The sender holds off here until every queued tick has been taken and
    // every expected status has come back, then lets the pipeline settle.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (ticks_taken != ticks_queued || expected_status.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    // Driver: a new tick goes out at the falling edge once the previous one
    // has been taken, unless the sender chooses to leave a gap.
    always @(negedge aclk) begin : driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || took_tick) begin
            if (tick_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                s_tdata <= tick_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random at the rate the current phase sets.
    always @(negedge aclk) begin : receiver
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: results are checked before the tick accepted at the same edge
    // is predicted, as that tick's status is registered in the result buffer first.
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            took_tick <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (expected_status.size() == 0) begin
                    report_mismatch("status with no tick outstanding", 8'h00, m_tdata);
                end else begin
                    want = expected_status.pop_front();
                    if (got.mode !== want.mode)
                        report_mismatch("mode", want.mode, got.mode);
                    if (got.fault_code !== want.fault_code)
                        report_mismatch("fault_code", want.fault_code, got.fault_code);
                    if (got.system_enable !== want.system_enable)
                        report_mismatch("system_enable", want.system_enable,
                                        got.system_enable);
                    if (got.hopper_enable !== want.hopper_enable)
                        report_mismatch("hopper_enable", want.hopper_enable,
                                        got.hopper_enable);
                    if (got.feed_drive !== want.feed_drive)
                        report_mismatch("feed_drive", want.feed_drive, got.feed_drive);
                    if (got.test_start !== want.test_start)
                        report_mismatch("test_start", want.test_start, got.test_start);
                end
                results_checked++;
            end
            if (s_tvalid && s_tready) begin
                expected_status.push_back(advance_supervisor(sample_t'(s_tdata)));
                ticks_taken++;
            end
            took_tick <= s_tvalid && s_tready;
        end
    end

    // Watchdog: too long without any item moving means the block has hung.
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0] feeder_ticks;
        logic [CNT_W-1:0] test_ticks;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, with short timeouts so that both can be seen to fire.
        // The counter comments give the elapsed ticks after each tick.
        send_gap_pct = 7;
        recv_stall_pct = 65;
        write_timeouts(16'd2, 16'd4);
        directed_ticks = '{
            TK_NONE,                     // idle and nothing pressed
            TK_START,                    // idle to running, system and hopper on
            TK_ISOLATED | TK_READY,      // feed and test issued, counters back to 0
            TK_NONE,                     // 1
            TK_START,                    // start in running drops the feed drive, 2
            TK_NONE,                     // 3
            TK_NONE,                     // 4
            TK_NONE,                     // 5, test timeout fires
            TK_START,                    // start clears the fault
            TK_START,                    // running again
            TK_ISOLATED | TK_READY,      // fresh feed and test
            TK_PAUSE,                    // 1, then paused and frozen
            TK_PAUSE | TK_START,         // back to running, start ignored when paused
            TK_NONE,                     // 2
            TK_START,                    // 3, feeder timeout and cleared in one tick
            TK_START,                    // running
            TK_PAUSE | TK_HOPPER_JAM,    // jam wins, pause flag left set
            TK_NONE,                     // fault, counters frozen
            TK_START,                    // idle, still frozen
            TK_START,                    // running, still frozen
            TK_PAUSE,                    // paused
            TK_PAUSE,                    // running, flag cleared
            TK_FEEDER_JAM,               // feeder jam fault
            TK_START,                    // idle
            TK_START,                    // running
            TK_STACKER_JAM,              // stacker jam fault
            TK_ALL                       // everything pressed while in fault
        };
        foreach (directed_ticks[i])
            queue_tick(sample_t'(directed_ticks[i]));
        wait_idle();

        // Random phases. Each starts from an idle block with a new pair of
        // timeouts, short ones so that faults are frequent and the range
        // extremes so that one or both never fire. The sender gaps and
        // receiver stalls change as the phases go on.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0, 1: begin
                    send_gap_pct = 7;
                    recv_stall_pct = 65;
                end
                2, 3: begin
                    send_gap_pct = 65;
                    recv_stall_pct = 7;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            feeder_ticks = CNT_W'($urandom_range(1, 15));
            test_ticks = CNT_W'($urandom_range(1, 15));
            case (phase)
                1: begin
                    feeder_ticks = 16'd1;
                    test_ticks = 16'd65534;
                end
                2: begin
                    feeder_ticks = 16'd65534;
                    test_ticks = 16'd1;
                end
                3: test_ticks = feeder_ticks;
                4: begin
                    feeder_ticks = 16'd65534;
                    test_ticks = 16'd65534;
                end
                default: ;
            endcase
            write_timeouts(feeder_ticks, test_ticks);
            queue_random_ticks(PHASE_TICKS);
            wait_idle();
        end

        $display("Summary: %0d ticks checked under %0d timeout settings.",
                 results_checked, settings_used);
        $display("Faults entered: feeder timeout %0d, test timeout %0d, jam %0d.",
                 faults_entered[FC_FEEDER], faults_entered[FC_TEST],
                 faults_entered[FC_JAM]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
